[hdl/pce_pkg.sv]
// Package with shared types, constants and helper functions for the Playfair encryption block.
`timescale 1ns / 1ps

package pce_pkg;

   localparam int SqCells = 25;
   localparam int Alpha   = 26;
   localparam int Side    = 5;

   localparam logic [7:0] AsciiA = 8'd65;
   localparam logic [4:0] IdxJ   = 5'd9;
   localparam logic [4:0] IdxX   = 5'd23;
   localparam logic [4:0] FillFull  = 5'(SqCells);
   localparam logic [4:0] SweepLast = 5'(Alpha - 1);

   typedef enum logic [1:0] {
      OP_CLEAR    = 2'd0,
      OP_KEY      = 2'd1,
      OP_COMPLETE = 2'd2,
      OP_MESSAGE  = 2'd3
   } pce_op_type;

   typedef struct packed {
      logic accept;
      logic sweep;
      logic rd_pos_a;
      logic rd_pos_b;
      logic calc;
      logic rd_sq_b;
      logic emit;
   } pce_cmd_type;

   typedef struct packed {
      logic start_fill;
      logic pair_go;
      logic sweep_last;
      logic out_free;
      logic second;
   } pce_stat_type;

   function automatic logic [2:0] row_of(input logic [4:0] pos);
      logic [2:0] r;
      if (pos >= 5'd20) begin
         r = 3'd4;
      end else if (pos >= 5'd15) begin
         r = 3'd3;
      end else if (pos >= 5'd10) begin
         r = 3'd2;
      end else if (pos >= 5'd5) begin
         r = 3'd1;
      end else begin
         r = 3'd0;
      end
      return r;
   endfunction

   function automatic logic [4:0] row_base(input logic [2:0] r);
      return {r, 2'b00} + {2'b00, r};
   endfunction

   function automatic logic [2:0] col_of(input logic [4:0] pos);
      logic [4:0] d;
      d = pos - row_base(row_of(pos));
      return d[2:0];
   endfunction

   function automatic logic [2:0] step5(input logic [2:0] v);
      return (v == 3'(Side - 1)) ? 3'd0 : v + 3'd1;
   endfunction

endpackage

[hdl/pce_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pce_ram #(
   parameter int WIDTH = 5,
   parameter int DEPTH = 26
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/pce_ctrl.sv]
// Controller state machine sequencing square fill and pair encryption.
`timescale 1ns / 1ps

module pce_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  pce_pkg::pce_stat_type st,
   output pce_pkg::pce_cmd_type  cmd
);
   import pce_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_FILL  = 7'b0000010,
      S_POS_A = 7'b0000100,
      S_POS_B = 7'b0001000,
      S_CALC  = 7'b0010000,
      S_SQ_B  = 7'b0100000,
      S_EMIT  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.accept = req_tvalid;
            if (req_tvalid) begin
               if (st.start_fill) begin
                  state_in = S_FILL;
               end else if (st.pair_go) begin
                  state_in = S_POS_A;
               end
            end
         end
         S_FILL: begin
            cmd.sweep = 1'b1;
            if (st.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_POS_A: begin
            cmd.rd_pos_a = 1'b1;
            state_in     = S_POS_B;
         end
         S_POS_B: begin
            cmd.rd_pos_b = 1'b1;
            state_in     = S_CALC;
         end
         S_CALC: begin
            cmd.calc = 1'b1;
            state_in = S_SQ_B;
         end
         S_SQ_B: begin
            cmd.rd_sq_b = 1'b1;
            state_in    = S_EMIT;
         end
         S_EMIT: begin
            if (st.out_free) begin
               cmd.emit = 1'b1;
               state_in = st.second ? S_POS_A : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

endmodule

[hdl/pce_datapath.sv]
// Datapath: key square storage, letter pairing, pair encryption and output register.
`timescale 1ns / 1ps

module pce_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            req_op,
   input  logic [7:0]            req_letter,
   input  logic                  req_last,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [6:0]            rsp_first,
   output logic [6:0]            rsp_second,
   output logic                  rsp_final,
   input  pce_pkg::pce_cmd_type  cmd,
   output pce_pkg::pce_stat_type st
);
   import pce_pkg::*;

   logic [Alpha-1:0] present_ff, present_in;
   logic [4:0] fill_ff, fill_in;
   logic [4:0] held_ff, held_in;
   logic       held_v_ff, held_v_in;
   logic [4:0] sweep_ff, sweep_in;
   logic [4:0] pa_ff, pa_in;
   logic [4:0] pb_ff, pb_in;
   logic       pfin_ff, pfin_in;
   logic       sec_ff, sec_in;
   logic [4:0] p1_ff, p1_in;
   logic [4:0] cell2_ff, cell2_in;
   logic [4:0] l1_ff, l1_in;
   logic       out_v_ff, out_v_in;
   logic [6:0] out_first_ff, out_first_in;
   logic [6:0] out_second_ff, out_second_in;
   logic       out_fin_ff, out_fin_in;

   pce_op_type op;
   logic       upper;
   logic [7:0] diff;
   logic [4:0] idx;
   logic       msg_ok;
   logic       letter_ok;
   logic       pair_go;
   logic       wr_go;
   logic [4:0] wr_idx;

   logic       pos_rd_en;
   logic [4:0] pos_rd_addr;
   logic [4:0] pos_rdata;
   logic       sq_rd_en;
   logic [4:0] sq_rd_addr;
   logic [4:0] sq_rdata;

   logic [2:0] r1, c1, r2, c2;
   logic [4:0] cell1, cell2;

   assign op     = pce_op_type'(req_op);
   assign upper  = (req_letter >= AsciiA) && (req_letter < AsciiA + 8'(Alpha));
   assign diff   = req_letter - AsciiA;
   assign idx    = diff[4:0];
   assign msg_ok = cmd.accept && (op == OP_MESSAGE) && (fill_ff == FillFull);
   assign letter_ok = upper && present_ff[idx];

   always_comb begin
      wr_go  = 1'b0;
      wr_idx = idx;
      if (cmd.sweep) begin
         wr_idx = sweep_ff;
         wr_go  = (sweep_ff != IdxJ) && !present_ff[sweep_ff] && (fill_ff < FillFull);
      end else if (cmd.accept && (op == OP_KEY) && upper) begin
         wr_go  = (idx != IdxJ) && !present_ff[idx] && (fill_ff < FillFull);
      end
   end

   always_comb begin
      pair_go   = 1'b0;
      pa_in     = pa_ff;
      pb_in     = pb_ff;
      pfin_in   = pfin_ff;
      sec_in    = sec_ff;
      held_in   = held_ff;
      held_v_in = held_v_ff;
      if (msg_ok) begin
         if (letter_ok && held_v_ff && (held_ff == idx)) begin
            pair_go   = 1'b1;
            pa_in     = held_ff;
            pb_in     = IdxX;
            pfin_in   = 1'b0;
            sec_in    = req_last;
            held_v_in = !req_last;
         end else if (letter_ok && held_v_ff) begin
            pair_go   = 1'b1;
            pa_in     = held_ff;
            pb_in     = idx;
            pfin_in   = req_last;
            sec_in    = 1'b0;
            held_v_in = 1'b0;
         end else if (letter_ok) begin
            held_in   = idx;
            pa_in     = idx;
            pb_in     = IdxX;
            pfin_in   = 1'b1;
            sec_in    = 1'b0;
            pair_go   = req_last;
            held_v_in = !req_last;
         end else if (req_last && held_v_ff) begin
            pair_go   = 1'b1;
            pa_in     = held_ff;
            pb_in     = IdxX;
            pfin_in   = 1'b1;
            sec_in    = 1'b0;
            held_v_in = 1'b0;
         end
      end else if (cmd.accept && (op == OP_CLEAR)) begin
         held_v_in = 1'b0;
      end else if (cmd.emit && sec_ff) begin
         pfin_in = 1'b1;
         sec_in  = 1'b0;
      end
   end

   always_comb begin
      present_in = present_ff;
      fill_in    = fill_ff;
      sweep_in   = sweep_ff;
      if (cmd.accept && (op == OP_CLEAR)) begin
         present_in = '0;
         fill_in    = '0;
      end else if (wr_go) begin
         present_in[wr_idx] = 1'b1;
         fill_in            = fill_ff + 5'd1;
      end
      if (cmd.accept && (op == OP_COMPLETE)) begin
         sweep_in = '0;
      end else if (cmd.sweep) begin
         sweep_in = sweep_ff + 5'd1;
      end
   end

   always_comb begin
      r1 = row_of(p1_ff);
      c1 = col_of(p1_ff);
      r2 = row_of(pos_rdata);
      c2 = col_of(pos_rdata);
      if (r1 == r2) begin
         c1 = step5(c1);
         c2 = step5(c2);
      end else if (c1 == c2) begin
         r1 = step5(r1);
         r2 = step5(r2);
      end else begin
         c1 = col_of(pos_rdata);
         c2 = col_of(p1_ff);
      end
      cell1 = row_base(r1) + {2'b00, c1};
      cell2 = row_base(r2) + {2'b00, c2};
   end

   assign pos_rd_en   = cmd.rd_pos_a || cmd.rd_pos_b;
   assign pos_rd_addr = cmd.rd_pos_b ? pb_ff : pa_ff;
   assign sq_rd_en    = cmd.calc || cmd.rd_sq_b;
   assign sq_rd_addr  = cmd.rd_sq_b ? cell2_ff : cell1;

   assign p1_in    = cmd.rd_pos_b ? pos_rdata : p1_ff;
   assign cell2_in = cmd.calc ? cell2 : cell2_ff;
   assign l1_in    = cmd.rd_sq_b ? sq_rdata : l1_ff;

   always_comb begin
      out_v_in      = out_v_ff;
      out_first_in  = out_first_ff;
      out_second_in = out_second_ff;
      out_fin_in    = out_fin_ff;
      if (cmd.emit) begin
         out_v_in      = 1'b1;
         out_first_in  = AsciiA[6:0] + {2'b00, l1_ff};
         out_second_in = AsciiA[6:0] + {2'b00, sq_rdata};
         out_fin_in    = pfin_ff;
      end else if (rsp_tready) begin
         out_v_in = 1'b0;
      end
   end

   pce_ram #(.WIDTH(5), .DEPTH(SqCells)) u_square (
      .clock   (clock),
      .wr_en   (wr_go),
      .wr_addr (fill_ff),
      .wr_data (wr_idx),
      .rd_en   (sq_rd_en),
      .rd_addr (sq_rd_addr),
      .rd_data (sq_rdata)
   );

   pce_ram #(.WIDTH(5), .DEPTH(Alpha)) u_position (
      .clock   (clock),
      .wr_en   (wr_go),
      .wr_addr (wr_idx),
      .wr_data (fill_ff),
      .rd_en   (pos_rd_en),
      .rd_addr (pos_rd_addr),
      .rd_data (pos_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
         fill_ff    <= '0;
         held_v_ff  <= 1'b0;
         out_v_ff   <= 1'b0;
         sec_ff     <= 1'b0;
         sweep_ff   <= '0;
      end else begin
         present_ff <= present_in;
         fill_ff    <= fill_in;
         held_v_ff  <= held_v_in;
         out_v_ff   <= out_v_in;
         sec_ff     <= sec_in;
         sweep_ff   <= sweep_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff       <= held_in;
      pa_ff         <= pa_in;
      pb_ff         <= pb_in;
      pfin_ff       <= pfin_in;
      p1_ff         <= p1_in;
      cell2_ff      <= cell2_in;
      l1_ff         <= l1_in;
      out_first_ff  <= out_first_in;
      out_second_ff <= out_second_in;
      out_fin_ff    <= out_fin_in;
   end

   assign st.start_fill = (op == OP_COMPLETE);
   assign st.pair_go    = pair_go;
   assign st.sweep_last = (sweep_ff == SweepLast);
   assign st.out_free   = !out_v_ff || rsp_tready;
   assign st.second     = sec_ff;

   assign rsp_tvalid = out_v_ff;
   assign rsp_first  = out_first_ff;
   assign rsp_second = out_second_ff;
   assign rsp_final  = out_fin_ff;

   a_fill_matches_present: assert property (@(posedge clock) disable iff (reset)
      $countones(present_ff) == 32'(fill_ff))
      else $error("fill count differs from number of placed letters");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FillFull)
      else $error("fill count beyond square size");

   a_held_is_placed: assert property (@(posedge clock) disable iff (reset)
      held_v_ff |-> present_ff[held_ff])
      else $error("held letter is not in the square");

   a_emit_into_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!out_v_ff || rsp_tready))
      else $error("result loaded over an untaken item");

endmodule

[hdl/playfair_cipher_encrypt.sv]
// Top level of the Playfair encryption block: controller and datapath.
//
// Channel  Dir  tdata                                tuser   tlast
// req_     in   letter[7:0]                          op[1:0] last
// rsp_     out  cipher_first[6:0], cipher_second[13:7] -     final_pair
//
// Clear and key items are taken in the idle state; a complete-square item walks the alphabet
// before the next item is taken. A message item that completes a pair reads the position RAM
// twice and the square RAM twice before its result goes out, and does so again for a second pair.
// Reset is synchronous and empties the square and the held letter.
// No item is taken while a pair is worked out. A result item waits in the output register
// and the next item is taken meanwhile; a new pair waits until that item has been taken.
`timescale 1ns / 1ps

module playfair_cipher_encrypt (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // letter[7:0]
   input  logic [1:0]  req_tuser,   // op[1:0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // cipher_first[6:0], cipher_second[13:7], zero[15:14]
   output logic        rsp_tlast
);
   import pce_pkg::*;

   pce_cmd_type  cmd;
   pce_stat_type st;
   logic [6:0]   first;
   logic [6:0]   second;

   pce_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   pce_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_op     (req_tuser),
      .req_letter (req_tdata),
      .req_last   (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_first  (first),
      .rsp_second (second),
      .rsp_final  (rsp_tlast),
      .cmd        (cmd),
      .st         (st)
   );

   assign rsp_tdata = {2'b00, second, first};

endmodule

[test/playfair_cipher_encrypt_tb.sv]
// Self-checking testbench for the Playfair encryption block with a scoreboard and random stalls.
`timescale 1ns / 1ps

module playfair_cipher_encrypt_tb;

   import pce_pkg::*;

   localparam int CycleLimit  = 600000;
   localparam int TargetItems = 1100;
   localparam int DrainCycles = 40;

   typedef struct {
      logic [6:0] cipher_first;
      logic [6:0] cipher_second;
      logic       final_pair;
   } cipher_pair_type;

   class playfair_scoreboard;
      logic [4:0]      cell_letter [SqCells];
      logic [4:0]      letter_cell [Alpha];
      bit              placed [Alpha];
      int              filled;
      logic [4:0]      held;
      bit              held_ok;
      cipher_pair_type pending_pairs [$];
      int              mismatches;
      int              pairs_checked;

      function new();
         foreach (placed[i]) placed[i] = 1'b0;
         filled        = 0;
         held          = '0;
         held_ok       = 1'b0;
         mismatches    = 0;
         pairs_checked = 0;
      endfunction

      function void place_letter(int idx);
         if (idx >= Alpha || idx == int'(IdxJ) || placed[idx] || filled >= SqCells) begin
            return;
         end
         cell_letter[filled] = 5'(idx);
         letter_cell[idx]    = 5'(filled);
         placed[idx]         = 1'b1;
         filled++;
      endfunction

      function void encrypt_pair(logic [4:0] a, logic [4:0] b, logic fin);
         int p1, p2, r1, c1, r2, c2, t;
         cipher_pair_type pr;
         p1 = int'(letter_cell[a]);
         p2 = int'(letter_cell[b]);
         r1 = p1 / Side;
         c1 = p1 % Side;
         r2 = p2 / Side;
         c2 = p2 % Side;
         if (r1 == r2) begin
            c1 = (c1 + 1) % Side;
            c2 = (c2 + 1) % Side;
         end else if (c1 == c2) begin
            r1 = (r1 + 1) % Side;
            r2 = (r2 + 1) % Side;
         end else begin
            t  = c1;
            c1 = c2;
            c2 = t;
         end
         pr.cipher_first  = 7'(int'(AsciiA) + int'(cell_letter[r1 * Side + c1]));
         pr.cipher_second = 7'(int'(AsciiA) + int'(cell_letter[r2 * Side + c2]));
         pr.final_pair    = fin;
         pending_pairs = {pending_pairs, pr};
      endfunction

      // Work out the pairs that one accepted item gives rise to.
      function void note_item(pce_op_type op, logic [7:0] ch, logic fin);
         bit         upper;
         logic [4:0] idx;
         upper = (ch >= AsciiA) && (int'(ch) < int'(AsciiA) + Alpha);
         idx   = upper ? 5'(ch - AsciiA) : 5'd0;
         case (op)
            OP_CLEAR: begin
               foreach (placed[i]) placed[i] = 1'b0;
               filled  = 0;
               held_ok = 1'b0;
            end
            OP_KEY: begin
               if (upper) place_letter(int'(idx));
            end
            OP_COMPLETE: begin
               for (int i = 0; i < Alpha; i++) place_letter(i);
            end
            default: begin
               if (filled >= SqCells) begin
                  if (upper && placed[idx]) begin
                     if (!held_ok) begin
                        held    = idx;
                        held_ok = 1'b1;
                     end else if (held == idx) begin
                        encrypt_pair(held, IdxX, 1'b0);
                     end else begin
                        encrypt_pair(held, idx, fin);
                        held_ok = 1'b0;
                     end
                  end
                  if (fin && held_ok) begin
                     encrypt_pair(held, IdxX, 1'b1);
                     held_ok = 1'b0;
                  end
               end
            end
         endcase
      endfunction

      function void check_pair(logic [6:0] got_first, logic [6:0] got_second, logic got_final);
         cipher_pair_type want;
         if (pending_pairs.size() == 0) begin
            $error("Unexpected result item: cipher_first %0d, cipher_second %0d, final_pair %0b",
                   got_first, got_second, got_final);
            mismatches++;
            return;
         end
         want = pending_pairs.pop_front();
         pairs_checked++;
         if (got_first !== want.cipher_first) begin
            $error("cipher_first: expected %0d, got %0d", want.cipher_first, got_first);
            mismatches++;
         end
         if (got_second !== want.cipher_second) begin
            $error("cipher_second: expected %0d, got %0d", want.cipher_second, got_second);
            mismatches++;
         end
         if (got_final !== want.final_pair) begin
            $error("final_pair: expected %0b, got %0b", want.final_pair, got_final);
            mismatches++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;    // letter[7:0]
   logic [1:0]  req_tuser = '0;    // op[1:0]
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // cipher_first[6:0], cipher_second[13:7], zero[15:14]
   logic        rsp_tlast;

   playfair_cipher_encrypt u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   playfair_scoreboard sb = new();

   int cycle_count = 0;
   int items_sent  = 0;
   int squares     = 0;
   int messages    = 0;
   int rsp_stall   = 0;
   bit rsp_taken   = 1'b0;
   bit steady      = 1'b0;

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Timed out after %0d cycles with %0d pairs outstanding.",
                  cycle_count, sb.pending_pairs.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_pair(rsp_tdata[6:0], rsp_tdata[13:7], rsp_tlast);
         rsp_taken = 1'b1;
      end
   end

   always @(negedge clock) begin
      if (rsp_taken) begin
         rsp_stall = steady ? 0 : $urandom_range(0, 5);
         rsp_taken = 1'b0;
      end
      if (rsp_stall > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic send_item(pce_op_type op, logic [7:0] ch, logic fin);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= ch;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_item(op, ch, fin);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_message(int len, bit with_last);
      int         r;
      logic [7:0] ch;
      logic [7:0] prev;
      prev = "A";
      for (int i = 0; i < len; i++) begin
         r = $urandom_range(0, 99);
         if (r < 4) begin
            send_item(pce_op_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
         end else begin
            if (r < 24) ch = prev;
            else if (r < 34) ch = "X";
            else if (r < 90) ch = 8'("A" + $urandom_range(0, 25));
            else ch = 8'($urandom_range(0, 255));
            send_item(OP_MESSAGE, ch, with_last && (i == len - 1));
            prev = ch;
         end
      end
      messages++;
   endtask

   task automatic build_square();
      int         r;
      logic [7:0] ch;
      if ($urandom_range(0, 99) < 85) send_item(OP_CLEAR, 8'($urandom_range(0, 255)), 1'b0);
      repeat ($urandom_range(0, 14)) begin
         r = $urandom_range(0, 99);
         if (r < 75) ch = 8'("A" + $urandom_range(0, 25));
         else if (r < 85) ch = 8'("a" + $urandom_range(0, 25));
         else if (r < 90) ch = "J";
         else ch = 8'($urandom_range(0, 255));
         send_item(OP_KEY, ch, 1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 99) < 92) send_item(OP_COMPLETE, 8'($urandom_range(0, 255)),
                                                1'($urandom_range(0, 1)));
      squares++;
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Key Z gives the square ZABCD / EFGHI / KLMNO / PQRST / UVWXY.
      send_item(OP_CLEAR, 8'h00, 1'b0);
      send_item(OP_MESSAGE, "A", 1'b1);
      send_item(OP_KEY, "Z", 1'b0);
      send_item(OP_KEY, 8'h00, 1'b1);
      send_item(OP_KEY, 8'hFF, 1'b0);
      send_item(OP_KEY, "J", 1'b0);
      send_item(OP_KEY, "Z", 1'b0);
      send_item(OP_KEY, "a", 1'b0);
      send_item(OP_COMPLETE, 8'h00, 1'b0);
      send_item(OP_COMPLETE, 8'hFF, 1'b1);
      send_item(OP_KEY, "B", 1'b0);
      send_item(OP_MESSAGE, "A", 1'b0);
      send_item(OP_MESSAGE, "B", 1'b0);
      send_item(OP_MESSAGE, "E", 1'b0);
      send_item(OP_MESSAGE, "K", 1'b0);
      send_item(OP_MESSAGE, "A", 1'b0);
      send_item(OP_MESSAGE, "G", 1'b0);
      send_item(OP_MESSAGE, "L", 1'b0);
      send_item(OP_MESSAGE, "L", 1'b0);
      send_item(OP_MESSAGE, "J", 1'b1);
      send_item(OP_MESSAGE, "X", 1'b0);
      send_item(OP_MESSAGE, "X", 1'b1);
      send_item(OP_MESSAGE, " ", 1'b1);
      send_item(OP_MESSAGE, "M", 1'b0);
      send_item(OP_MESSAGE, "@", 1'b1);
      squares = 1;

      while (items_sent < TargetItems) begin
         steady = ($urandom_range(0, 99) < 20);
         build_square();
         repeat ($urandom_range(1, 4)) begin
            steady = ($urandom_range(0, 99) < 20);
            send_message($urandom_range(1, 14), $urandom_range(0, 99) < 90);
         end
      end
      req_tvalid <= 1'b0;

      while (sb.pending_pairs.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (sb.pending_pairs.size() != 0) begin
         $error("%0d expected pairs never arrived", sb.pending_pairs.size());
         sb.mismatches++;
      end

      $display("Drove %0d items over %0d key squares and %0d messages.",
               items_sent, squares, messages);
      $display("Checked %0d cipher pairs with %0d mismatches.", sb.pairs_checked, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
